// ===== rtl/core/cmam_pkg.sv =====
// Package for the per-class moving average memory.
// Sizes, register indexes, request codes and transfer payload types.
// Used by class_moving_average_memory; no dependencies.
package cmam_pkg;

  localparam int MAX_CLASSES = 16;
  localparam int SAMPLE_LEN  = 1024;
  localparam int DATA_WIDTH  = 16;

  localparam int CLASS_W     = $clog2(MAX_CLASSES);
  localparam int SAMPLE_W    = $clog2(SAMPLE_LEN);
  localparam int ADDR_W      = CLASS_W + SAMPLE_W;
  localparam int STORE_DEPTH = MAX_CLASSES * SAMPLE_LEN;

  localparam int FRAC_W   = 17;
  localparam int PROD_W   = FRAC_W + 1 + DATA_WIDTH;
  localparam int ACC_W    = PROD_W + 1;
  localparam int FRAC_SH  = 16;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = OUT_PTR_W + 1;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_AVG_FRACTION  = 2'd0,
    REG_CLASS_COUNT   = 2'd1,
    REG_IGNORE_ENABLE = 2'd2,
    REG_IGNORE_CLASS  = 2'd3
  } reg_idx_t;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_OUTPUT = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic [7:0]                    class_label;
    logic [9:0]                    element_index;
    logic signed [DATA_WIDTH-1:0]  sample_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  out_value;
    logic                          label_error;
  } out_t;

  // read stage
  typedef struct packed {
    logic                          vld;
    logic                          wr;
    logic                          rd_mem;
    logic                          res;
    logic                          label_error;
    logic [ADDR_W-1:0]             addr;
    logic signed [DATA_WIDTH-1:0]  value;
    logic signed [DATA_WIDTH-1:0]  pass;
  } rd_stage_t;

  // blend / write stage
  typedef struct packed {
    logic                          vld;
    logic                          wr;
    logic                          res;
    logic                          label_error;
    logic [ADDR_W-1:0]             addr;
    logic signed [PROD_W-1:0]      p_val;
    logic signed [PROD_W-1:0]      p_ent;
    logic signed [DATA_WIDTH-1:0]  out_value;
  } wr_stage_t;

endpackage

// ===== rtl/core/cmam_ram.sv =====
// Generic single-write, single-read synchronous RAM.
// Read data is registered; a read at the address being written returns old data.
// No dependencies.
module cmam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/class_moving_average_memory.sv =====
// Per-class moving average memory: top level.
// Depends on cmam_pkg and cmam_ram.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one element of a
//   labelled sample. An update element (req_type 0) blends its value into
//   the stored class mean, entry = ((1-f)*value + f*entry) rounded, and
//   gives no result unless the label is bad. An output element (req_type 1)
//   returns the stored mean, or the input when the ignore label matches.
//   Output channel out_valid / out_stall / out_data carries the results.
//   Write registers over the APB port only while idle; the block never checks.
// Timing:
//   Each element is registered in s1 and then in s2, and its result goes
//   into the output buffer, whose non-empty state raises out_valid. One
//   element is taken per cycle while in_stall is low; the read-modify-write
//   of the mean store spans three stages, so an element that hits the same
//   entry as the update just before it stalls while that update is in stage 1.
// Reset:
//   Registers return to their reset values and the 16384-entry store is
//   swept to zero, one entry per cycle; in_stall is high until the sweep
//   ends. APB writes are taken throughout.
// Stall:
//   Results queue in a 4-entry output buffer; in_stall rises once the
//   buffer plus results in flight would overflow it.
module class_moving_average_memory (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cmam_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cmam_pkg::out_t                  out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cmam_pkg::PADDR_W-1:0]    paddr,
  input  logic [cmam_pkg::PDATA_W-1:0]    pwdata,
  output logic [cmam_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  // configuration registers
  logic [cmam_pkg::FRAC_W-1:0]  avg_fraction;
  logic [4:0]                   class_count;
  logic                         ignore_enable;
  logic [3:0]                   ignore_class;
  logic                         cfg_wr;
  cmam_pkg::reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cmam_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_fraction  <= '0;
      class_count   <= 5'd16;
      ignore_enable <= 1'b0;
      ignore_class  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cmam_pkg::REG_AVG_FRACTION:  avg_fraction  <= pwdata[cmam_pkg::FRAC_W-1:0];
        cmam_pkg::REG_CLASS_COUNT:   class_count   <= pwdata[4:0];
        cmam_pkg::REG_IGNORE_ENABLE: ignore_enable <= pwdata[0];
        cmam_pkg::REG_IGNORE_CLASS:  ignore_class  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      cmam_pkg::REG_AVG_FRACTION:  prdata = cmam_pkg::PDATA_W'(avg_fraction);
      cmam_pkg::REG_CLASS_COUNT:   prdata = cmam_pkg::PDATA_W'(class_count);
      cmam_pkg::REG_IGNORE_ENABLE: prdata = cmam_pkg::PDATA_W'(ignore_enable);
      cmam_pkg::REG_IGNORE_CLASS:  prdata = cmam_pkg::PDATA_W'(ignore_class);
      default:                     prdata = '0;
    endcase
  end

  logic [cmam_pkg::FRAC_W-1:0] frac;
  logic [cmam_pkg::FRAC_W-1:0] frac_inv;
  assign frac     = (avg_fraction > cmam_pkg::FRAC_ONE) ? cmam_pkg::FRAC_ONE : avg_fraction;
  assign frac_inv = cmam_pkg::FRAC_ONE - frac;

  // clearing sweep after reset
  logic                        clr_active;
  logic [cmam_pkg::ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == cmam_pkg::ADDR_W'(cmam_pkg::STORE_DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // stage 0: decode the incoming element
  logic                           accept;
  logic                           bad;
  logic                           elem_ok;
  logic                           ign;
  logic                           in_wr;
  logic                           in_rd_mem;
  logic                           in_res;
  logic [cmam_pkg::ADDR_W-1:0]    in_addr;
  logic signed [cmam_pkg::DATA_WIDTH-1:0] in_pass;
  logic                           hazard;
  logic                           full;

  cmam_pkg::rd_stage_t s1;
  cmam_pkg::wr_stage_t s2;

  logic [cmam_pkg::OUT_CNT_W-1:0] ocnt;
  logic [cmam_pkg::OUT_CNT_W-1:0] pending;

  assign bad = (in_data.class_label >= 8'(class_count)) ||
               (32'(in_data.class_label) >= cmam_pkg::MAX_CLASSES);
  assign elem_ok   = 32'(in_data.element_index) < cmam_pkg::SAMPLE_LEN;
  assign ign       = ignore_enable && (in_data.class_label == 8'(ignore_class));
  assign in_addr   = {in_data.class_label[cmam_pkg::CLASS_W-1:0],
                      in_data.element_index[cmam_pkg::SAMPLE_W-1:0]};
  assign in_wr     = (in_data.req_type == cmam_pkg::REQ_UPDATE) && !bad && elem_ok;
  assign in_rd_mem = (in_data.req_type == cmam_pkg::REQ_OUTPUT) && !bad && elem_ok && !ign;
  assign in_res    = bad || (in_data.req_type == cmam_pkg::REQ_OUTPUT);
  assign in_pass   = ((in_data.req_type == cmam_pkg::REQ_OUTPUT) && ign) ?
                     in_data.sample_value : '0;

  // the write of the update now in stage 1 lands after this element's read
  assign hazard = s1.vld && s1.wr && (in_wr || in_rd_mem) && (s1.addr == in_addr);

  assign pending = ocnt + cmam_pkg::OUT_CNT_W'(s1.vld && s1.res) +
                   cmam_pkg::OUT_CNT_W'(s2.vld && s2.res);
  assign full    = 32'(pending) >= cmam_pkg::OUT_DEPTH;

  assign in_stall = clr_active || hazard || full;
  assign accept   = in_valid && !in_stall;

  // mean store
  logic                                  ram_we;
  logic [cmam_pkg::ADDR_W-1:0]           ram_waddr;
  logic [cmam_pkg::DATA_WIDTH-1:0]       ram_wdata;
  logic [cmam_pkg::DATA_WIDTH-1:0]       ram_rdata;
  logic signed [cmam_pkg::DATA_WIDTH-1:0] blend_res;

  assign ram_we    = clr_active || (s2.vld && s2.wr);
  assign ram_waddr = clr_active ? clr_addr : s2.addr;
  assign ram_wdata = clr_active ? '0 : blend_res;

  cmam_ram #(
    .WIDTH (cmam_pkg::DATA_WIDTH),
    .DEPTH (cmam_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld <= 1'b0;
    end else begin
      s1.vld <= accept;
    end
    if (accept) begin
      s1.wr          <= in_wr;
      s1.rd_mem      <= in_rd_mem;
      s1.res         <= in_res;
      s1.label_error <= bad;
      s1.addr        <= in_addr;
      s1.value       <= in_data.sample_value;
      s1.pass        <= in_pass;
    end
  end

  // stage 1: entry with forwarding of the previous cycle's write, then multiply
  logic                                   wb_vld;
  logic [cmam_pkg::ADDR_W-1:0]            wb_addr;
  logic signed [cmam_pkg::DATA_WIDTH-1:0] wb_data;
  logic signed [cmam_pkg::DATA_WIDTH-1:0] entry;

  assign entry = (wb_vld && (wb_addr == s1.addr)) ? wb_data : $signed(ram_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.vld <= 1'b0;
    end else begin
      s2.vld <= s1.vld;
    end
    s2.wr          <= s1.wr;
    s2.res         <= s1.res;
    s2.label_error <= s1.label_error;
    s2.addr        <= s1.addr;
    s2.p_val       <= $signed({1'b0, frac_inv}) * s1.value;
    s2.p_ent       <= $signed({1'b0, frac}) * entry;
    s2.out_value   <= s1.rd_mem ? entry : s1.pass;
  end

  // stage 2: sum, round half up, saturate, write back
  logic signed [cmam_pkg::ACC_W-1:0]           acc;
  logic signed [cmam_pkg::ACC_W-cmam_pkg::FRAC_SH-1:0] rnd;
  localparam int RND_W = cmam_pkg::ACC_W - cmam_pkg::FRAC_SH;

  assign acc = cmam_pkg::ACC_W'(s2.p_val) + cmam_pkg::ACC_W'(s2.p_ent) +
               cmam_pkg::ACC_W'(1 << (cmam_pkg::FRAC_SH - 1));
  assign rnd = acc[cmam_pkg::ACC_W-1:cmam_pkg::FRAC_SH];

  always_comb begin
    if (rnd > RND_W'((1 << (cmam_pkg::DATA_WIDTH - 1)) - 1)) begin
      blend_res = {1'b0, {(cmam_pkg::DATA_WIDTH-1){1'b1}}};
    end else if (rnd < -RND_W'(1 << (cmam_pkg::DATA_WIDTH - 1))) begin
      blend_res = {1'b1, {(cmam_pkg::DATA_WIDTH-1){1'b0}}};
    end else begin
      blend_res = rnd[cmam_pkg::DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_vld <= 1'b0;
    end else begin
      wb_vld <= s2.vld && s2.wr;
    end
    wb_addr <= s2.addr;
    wb_data <= blend_res;
  end

  // result buffer
  cmam_pkg::out_t                  obuf [cmam_pkg::OUT_DEPTH];
  logic [cmam_pkg::OUT_PTR_W-1:0]  wptr;
  logic [cmam_pkg::OUT_PTR_W-1:0]  rptr;
  logic                            push;
  logic                            pop;

  assign push      = s2.vld && s2.res;
  assign out_valid = ocnt != '0;
  assign pop       = out_valid && !out_stall;
  assign out_data  = obuf[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      ocnt <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      ocnt <= ocnt + cmam_pkg::OUT_CNT_W'(push) - cmam_pkg::OUT_CNT_W'(pop);
    end
    if (push) begin
      obuf[wptr].out_value   <= s2.out_value;
      obuf[wptr].label_error <= s2.label_error;
    end
  end

endmodule
